[hw/rtl/keyed_route_list_with_cursor_core_defines.svh]
// assertion macros used by the checker file krl_checker.sv
`ifndef KEYED_ROUTE_LIST_WITH_CURSOR_CORE_DEFINES_SVH
`define KEYED_ROUTE_LIST_WITH_CURSOR_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define KRL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KRL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/krl_pkg.sv]
// shared types, constants and helpers of the keyed route list
package krl_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = 5;
    localparam int SUM_W = 28;
    localparam int KEY_W = 32;
    localparam int VAL_W = 24;
    localparam logic [CNT_W-1:0] LIMIT_RST = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_REMOVE  = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [KEY_W-1:0] entry_key;
        logic [VAL_W-1:0] leg_time;
        logic [VAL_W-1:0] leg_fuel;
    } req_t;

    typedef struct packed {
        logic             accepted;
        logic [CNT_W-1:0] entry_count;
        logic [CNT_W-1:0] cursor_pos;
        logic             route_done;
        logic [SUM_W-1:0] time_total;
        logic [SUM_W-1:0] time_elapsed;
        logic [SUM_W-1:0] time_left;
        logic [SUM_W-1:0] fuel_total;
        logic [SUM_W-1:0] fuel_left;
        logic [CNT_W-1:0] legs_left;
        logic [KEY_W-1:0] current_key;
    } rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] leg_time;
        logic [VAL_W-1:0] leg_fuel;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SEARCH,
        ST_APPLY,
        ST_SHIFT,
        ST_SUM,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic sweep_init;
        logic sweep_from_pos;
        logic sweep_run;
        logic search_cmp;
        logic shift_wr;
        logic add_wr;
        logic remove_commit;
        logic advance;
        logic acc_clear;
        logic acc_run;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       found;
        logic       sweep_done;
        logic       add_room;
        logic       can_advance;
    } status_t;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            sat_add = s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
        end
    endfunction

endpackage

[hw/rtl/keyed_route_list_with_cursor_core.sv]
// keyed route list with cursor: top level
//
// requests enter on in_valid/in_ready with an in_req struct: add an entry,
// remove an entry by key, or advance the cursor. every request yields one
// result on out_valid/out_ready carrying out_rsp with the list status and
// the saturated time and fuel sums.
// entry_limit is written through cfg_valid/cfg_ready/cfg_data; the user
// must write it only while idle, and the block does not enforce this;
// cfg_ready is always high. one request is worked at a time; the entry
// memory has one read and one write port and each sweep reads one entry
// per cycle. the list holds at most 16 entries. the result becomes valid
// in the same cycle that the block returns to idle and can take the next
// request.
// in_ready is high while the block is idle, also while a result still sits
// in the output register; a stalled receiver holds the finished result
// there and the next result waits until that one is taken.
// reset empties the list, sets the cursor to 0 and entry_limit to 16;
// no clearing pass is needed.
module keyed_route_list_with_cursor_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  krl_pkg::req_t  in_req,
    output logic           out_valid,
    input  logic           out_ready,
    output krl_pkg::rsp_t  out_rsp,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [4:0]     cfg_data
);
    import krl_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    krl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    krl_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_req    (in_req),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_rsp   (out_rsp)
    );

endmodule

[hw/rtl/krl_ctrl.sv]
// sequencer for the route list: search, compaction and summing sweeps
module krl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  krl_pkg::status_t  status,
    output krl_pkg::cmd_t     cmd
);
    import krl_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign in_ready  = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DISPATCH;
            end
            ST_DISPATCH:
            begin
                if (status.op inside {OP_ADD, OP_REMOVE})
                    state_next = ST_SEARCH;
                else
                    state_next = ST_SUM;
            end
            ST_SEARCH:
            begin
                if (status.found || status.sweep_done)
                    state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (status.op != OP_ADD && status.found)
                    state_next = ST_SHIFT;
                else
                    state_next = ST_SUM;
            end
            ST_SHIFT:
            begin
                if (status.sweep_done)
                    state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (status.sweep_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = in_valid;
            end
            ST_DISPATCH:
            begin
                cmd.sweep_init = 1'b1;
                if (!(status.op inside {OP_ADD, OP_REMOVE}))
                begin
                    cmd.acc_clear = 1'b1;
                    cmd.advance   = (status.op == OP_ADVANCE) && status.can_advance;
                end
            end
            ST_SEARCH:
            begin
                cmd.sweep_run  = 1'b1;
                cmd.search_cmp = 1'b1;
            end
            ST_APPLY:
            begin
                cmd.sweep_init = 1'b1;
                if (status.op == OP_ADD)
                begin
                    cmd.add_wr    = !status.found && status.add_room;
                    cmd.acc_clear = 1'b1;
                end
                else if (status.found)
                    cmd.sweep_from_pos = 1'b1;
                else
                    cmd.acc_clear = 1'b1;
            end
            ST_SHIFT:
            begin
                cmd.sweep_run = 1'b1;
                cmd.shift_wr  = 1'b1;
                if (status.sweep_done)
                begin
                    cmd.remove_commit = 1'b1;
                    cmd.sweep_init    = 1'b1;
                    cmd.acc_clear     = 1'b1;
                end
            end
            ST_SUM:
            begin
                cmd.sweep_run = 1'b1;
                cmd.acc_run   = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[hw/rtl/krl_dp.sv]
// entry memory, counters, sweep pointer, accumulators and result register
module krl_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  krl_pkg::req_t     in_req,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [4:0]        cfg_data,
    input  krl_pkg::cmd_t     cmd,
    output krl_pkg::status_t  status,
    output krl_pkg::rsp_t     out_rsp
);
    import krl_pkg::*;

    entry_t           mem [DEPTH];
    entry_t           rd_data_reg;
    req_t             req_reg;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    logic [CNT_W-1:0] limit_reg,  limit_next;
    logic [CNT_W-1:0] fill_reg,   fill_next;
    logic [CNT_W-1:0] cursor_reg, cursor_next;
    logic [CNT_W-1:0] idx_reg,    idx_next;
    logic             pend_reg,   pend_next;
    logic [IDX_W-1:0] pidx_reg,   pidx_next;
    logic             found_reg,  found_next;
    logic [IDX_W-1:0] pos_reg,    pos_next;
    logic             ok_reg,     ok_next;

    logic [SUM_W-1:0] t_before_reg, t_before_next;
    logic [SUM_W-1:0] t_after_reg,  t_after_next;
    logic [SUM_W-1:0] f_before_reg, f_before_next;
    logic [SUM_W-1:0] f_after_reg,  f_after_next;
    logic [KEY_W-1:0] ckey_reg,     ckey_next;

    logic             issue;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic [CNT_W-1:0] pidx_ext;
    logic [CNT_W-1:0] pos_ext;
    logic [CNT_W-1:0] fill_dec;
    logic [CNT_W-1:0] cur_adj;

    assign issue    = cmd.sweep_run && (idx_reg < fill_reg);
    assign pidx_ext = CNT_W'(pidx_reg);
    assign pos_ext  = CNT_W'(pos_reg);
    assign fill_dec = fill_reg - CNT_W'(1);
    assign cur_adj  = (pos_ext < cursor_reg) ? cursor_reg - CNT_W'(1) : cursor_reg;

    assign status.op          = req_reg.opcode;
    assign status.found       = found_reg;
    assign status.sweep_done  = (idx_reg >= fill_reg) && !pend_reg;
    assign status.add_room    = (fill_reg < limit_reg) && (fill_reg < CNT_W'(DEPTH));
    assign status.can_advance = cursor_reg < fill_reg;

    assign out_rsp = rsp_reg;

    // one write port: append on add, move down one place during compaction
    always_comb
    begin
        wr_en   = cmd.add_wr || (cmd.shift_wr && pend_reg);
        wr_addr = cmd.add_wr ? fill_reg[IDX_W-1:0] : pidx_reg - IDX_W'(1);
        wr_data = rd_data_reg;
        if (cmd.add_wr)
        begin
            wr_data.key      = req_reg.entry_key;
            wr_data.leg_time = req_reg.leg_time;
            wr_data.leg_fuel = req_reg.leg_fuel;
        end
    end

    always_comb
    begin
        limit_next  = limit_reg;
        fill_next   = fill_reg;
        cursor_next = cursor_reg;
        idx_next    = idx_reg;
        pend_next   = issue;
        pidx_next   = pidx_reg;
        found_next  = found_reg;
        pos_next    = pos_reg;
        ok_next     = ok_reg;

        if (cfg_valid && cfg_ready)
            limit_next = cfg_data;

        if (cmd.sweep_init)
        begin
            idx_next  = cmd.sweep_from_pos ? pos_ext + CNT_W'(1) : '0;
            pend_next = 1'b0;
        end
        else if (issue)
        begin
            idx_next  = idx_reg + CNT_W'(1);
            pidx_next = idx_reg[IDX_W-1:0];
        end

        if (cmd.capture)
        begin
            found_next = 1'b0;
            ok_next    = 1'b0;
        end
        else if (cmd.search_cmp && pend_reg && !found_reg
                 && rd_data_reg.key == req_reg.entry_key)
        begin
            found_next = 1'b1;
            pos_next   = pidx_reg;
        end

        if (cmd.add_wr)
        begin
            fill_next = fill_reg + CNT_W'(1);
            ok_next   = 1'b1;
        end
        if (cmd.advance)
        begin
            cursor_next = cursor_reg + CNT_W'(1);
            ok_next     = 1'b1;
        end
        if (cmd.remove_commit)
        begin
            fill_next   = fill_dec;
            cursor_next = (cur_adj > fill_dec) ? fill_dec : cur_adj;
            ok_next     = 1'b1;
        end
    end

    // sums split at the cursor; totals are formed when the result is loaded
    always_comb
    begin
        t_before_next = t_before_reg;
        t_after_next  = t_after_reg;
        f_before_next = f_before_reg;
        f_after_next  = f_after_reg;
        ckey_next     = ckey_reg;
        if (cmd.acc_clear)
        begin
            t_before_next = '0;
            t_after_next  = '0;
            f_before_next = '0;
            f_after_next  = '0;
            ckey_next     = '0;
        end
        else if (cmd.acc_run && pend_reg)
        begin
            if (pidx_ext < cursor_reg)
            begin
                t_before_next = sat_add(t_before_reg, SUM_W'(rd_data_reg.leg_time));
                f_before_next = sat_add(f_before_reg, SUM_W'(rd_data_reg.leg_fuel));
            end
            else
            begin
                t_after_next = sat_add(t_after_reg, SUM_W'(rd_data_reg.leg_time));
                f_after_next = sat_add(f_after_reg, SUM_W'(rd_data_reg.leg_fuel));
            end
            if (pidx_ext == cursor_reg)
                ckey_next = rd_data_reg.key;
        end
    end

    always_comb
    begin
        rsp_next              = rsp_reg;
        rsp_next.accepted     = ok_reg;
        rsp_next.entry_count  = fill_reg;
        rsp_next.cursor_pos   = cursor_reg;
        rsp_next.route_done   = cursor_reg >= fill_reg;
        rsp_next.time_total   = sat_add(t_before_reg, t_after_reg);
        rsp_next.time_elapsed = t_before_reg;
        rsp_next.time_left    = t_after_reg;
        rsp_next.fuel_total   = sat_add(f_before_reg, f_after_reg);
        rsp_next.fuel_left    = f_after_reg;
        rsp_next.legs_left    = (fill_reg > cursor_reg) ? fill_reg - cursor_reg : '0;
        rsp_next.current_key  = ckey_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= LIMIT_RST;
            fill_reg   <= '0;
            cursor_reg <= '0;
            idx_reg    <= '0;
            pend_reg   <= 1'b0;
            found_reg  <= 1'b0;
            ok_reg     <= 1'b0;
        end
        else
        begin
            limit_reg  <= limit_next;
            fill_reg   <= fill_next;
            cursor_reg <= cursor_next;
            idx_reg    <= idx_next;
            pend_reg   <= pend_next;
            found_reg  <= found_next;
            ok_reg     <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg     <= pidx_next;
        pos_reg      <= pos_next;
        t_before_reg <= t_before_next;
        t_after_reg  <= t_after_next;
        f_before_reg <= f_before_next;
        f_after_reg  <= f_after_next;
        ckey_reg     <= ckey_next;
        if (cmd.capture)
            req_reg <= in_req;
        if (cmd.out_load)
            rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
    end

endmodule

[hw/rtl/krl_checker.sv]
// port-level checks of the route list, bound to the top level
`include "keyed_route_list_with_cursor_core_defines.svh"

module krl_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           out_valid,
    input logic           out_ready,
    input krl_pkg::rsp_t  out_rsp
);
    import krl_pkg::*;

    `KRL_ASSERT_IMP(a_done_flag, out_valid,
        out_rsp.route_done == (out_rsp.cursor_pos >= out_rsp.entry_count),
        "route_done disagrees with cursor and count")

    `KRL_ASSERT_IMP(a_legs_left, out_valid,
        out_rsp.cursor_pos <= out_rsp.entry_count &&
        out_rsp.legs_left == out_rsp.entry_count - out_rsp.cursor_pos,
        "legs_left or cursor out of step with count")

    `KRL_ASSERT_IMP(a_done_empty, out_valid && out_rsp.route_done,
        out_rsp.current_key == '0 && out_rsp.time_left == '0 &&
        out_rsp.fuel_left == '0,
        "finished route still shows work left")

    `KRL_ASSERT_IMP(a_totals, out_valid,
        out_rsp.time_total >= out_rsp.time_elapsed &&
        out_rsp.time_total >= out_rsp.time_left &&
        out_rsp.fuel_total >= out_rsp.fuel_left,
        "total below a partial sum")

    `KRL_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_rsp),
        "stalled result changed")

endmodule

bind keyed_route_list_with_cursor_core krl_checker u_krl_checker (.*);
